// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TMD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition is followed by another on the next edge.
`define TMD_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/tmd_pkg.sv =====
`default_nettype none

package tmd_pkg;

  // Archive geometry
  localparam int unsigned BlockLen  = 512;
  localparam int unsigned HdrCntW   = 9;
  localparam int unsigned NameLen   = 100;
  localparam int unsigned SizePos   = 124;
  localparam int unsigned SizeLen   = 12;
  localparam int unsigned TailLenW  = 3;

  // Characters
  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrSeven = 8'h37;
  localparam logic [7:0] ChrUpA   = 8'h41;
  localparam logic [7:0] ChrUpZ   = 8'h5a;
  localparam logic [7:0] CaseGap  = 8'h20;

  // Case-folded name suffixes
  localparam logic [31:0] TagHdb = 32'h2e686462;
  localparam logic [31:0] TagHdu = 32'h2e686475;
  localparam logic [31:0] TagHsb = 32'h2e687362;
  localparam logic [31:0] TagHsu = 32'h2e687375;
  localparam logic [31:0] TagMdb = 32'h2e6d6462;
  localparam logic [31:0] TagMdu = 32'h2e6d6475;

  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_DATA = 2'd1,
    PH_PAD  = 2'd2,
    PH_END  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HASH = 2'd0,
    KIND_SECT = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  // Summary of a completed header, valid on its last byte
  typedef struct packed {
    logic        done;
    logic        arch_end;
    kind_e       kind;
    logic [31:0] size;
  } hdr_info_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        member_kind;
    logic        member_last;
    logic        archive_end;
    logic [31:0] member_number;
  } res_t;

  function automatic kind_e classify(input logic [31:0] tail,
                                     input logic [TailLenW-1:0] seen);
    kind_e k;
    k = KIND_NONE;
    if (seen >= TailLenW'(4)) begin
      if (tail == TagHdb || tail == TagHdu || tail == TagHsb || tail == TagHsu) begin
        k = KIND_HASH;
      end else if (tail == TagMdb || tail == TagMdu) begin
        k = KIND_SECT;
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tmd_hdr_parse.sv =====
`default_nettype none

module tmd_hdr_parse (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              hdr_beat_i,
  input  wire logic [7:0]        byte_i,
  output tmd_pkg::hdr_info_t     info_o
);

  logic [tmd_pkg::HdrCntW-1:0]  count_q, count_d;
  logic                         first_zero_q, first_zero_d;
  logic [31:0]                  tail_q, tail_d;
  logic [tmd_pkg::TailLenW-1:0] seen_q, seen_d;
  logic                         name_end_q, name_end_d;
  logic [31:0]                  size_q, size_d;
  logic                         size_end_q, size_end_d;
  logic [7:0]                   folded;
  logic                         last_pos;

  assign last_pos = (count_q == tmd_pkg::HdrCntW'(tmd_pkg::BlockLen - 1));

  // Fold upper case letters to lower case
  always_comb begin
    folded = byte_i;
    if (byte_i inside {[tmd_pkg::ChrUpA:tmd_pkg::ChrUpZ]}) begin
      folded = byte_i + tmd_pkg::CaseGap;
    end
  end

  // Collect name tail and octal size while the header streams in
  always_comb begin
    count_d      = count_q;
    first_zero_d = first_zero_q;
    tail_d       = tail_q;
    seen_d       = seen_q;
    name_end_d   = name_end_q;
    size_d       = size_q;
    size_end_d   = size_end_q;
    if (hdr_beat_i) begin
      count_d = count_q + tmd_pkg::HdrCntW'(1);
      if (count_q == '0) begin
        first_zero_d = (byte_i == tmd_pkg::ChrNul);
      end
      if (count_q < tmd_pkg::HdrCntW'(tmd_pkg::NameLen) && !name_end_q) begin
        if (byte_i == tmd_pkg::ChrNul) begin
          name_end_d = 1'b1;
        end else begin
          tail_d = {tail_q[23:0], folded};
          if (seen_q < tmd_pkg::TailLenW'(4)) begin
            seen_d = seen_q + tmd_pkg::TailLenW'(1);
          end
        end
      end
      if (count_q >= tmd_pkg::HdrCntW'(tmd_pkg::SizePos) &&
          count_q < tmd_pkg::HdrCntW'(tmd_pkg::SizePos + tmd_pkg::SizeLen) &&
          !size_end_q) begin
        if (byte_i inside {[tmd_pkg::ChrZero:tmd_pkg::ChrSeven]}) begin
          size_d = {size_q[28:0], byte_i[2:0]};
        end else begin
          size_end_d = 1'b1;
        end
      end
      // Clear for the next header after its last byte
      if (last_pos) begin
        count_d      = '0;
        first_zero_d = 1'b0;
        tail_d       = '0;
        seen_d       = '0;
        name_end_d   = 1'b0;
        size_d       = '0;
        size_end_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      first_zero_q <= 1'b0;
      tail_q       <= '0;
      seen_q       <= '0;
      name_end_q   <= 1'b0;
      size_q       <= '0;
      size_end_q   <= 1'b0;
    end else begin
      count_q      <= count_d;
      first_zero_q <= first_zero_d;
      tail_q       <= tail_d;
      seen_q       <= seen_d;
      name_end_q   <= name_end_d;
      size_q       <= size_d;
      size_end_q   <= size_end_d;
    end
  end

  assign info_o.done     = hdr_beat_i && last_pos;
  assign info_o.arch_end = first_zero_q;
  assign info_o.kind     = tmd_pkg::classify(tail_q, seen_q);
  assign info_o.size     = size_q;

endmodule

`default_nettype wire

// ===== rtl/tmd_out_stage.sv =====
`default_nettype none

`include "assert_macros.svh"

module tmd_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          res_valid_i,
  input  wire tmd_pkg::res_t res_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tmd_pkg::res_t      out_o
);

  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  tmd_pkg::res_t out_q, out_d;
  tmd_pkg::res_t skid_q, skid_d;
  logic          drain;

  assign drain = !out_valid_q || !out_stall_i;

  // Refill the output register from the skid first, park a beat when stalled
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (drain) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res_i;
        out_valid_d = res_valid_i;
      end
    end else if (res_valid_i) begin
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `TMD_ASSERT(a_skid_behind_out, clk_i, rst_ni, !skid_valid_q || out_valid_q, "skid holds a beat while the output register is empty")
  `TMD_ASSERT(a_no_beat_when_full, clk_i, rst_ni, !(skid_valid_q && res_valid_i), "result arrived while the skid was full")

endmodule

`default_nettype wire

// ===== rtl/tar_member_deframer.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+---------------------------------------------
// input    | in_valid_i / in_stall_o   | stream_byte_i
// output   | out_valid_o / out_stall_i | data_byte_o member_kind_o member_last_o
//          |                           | archive_end_o member_number_o
//
// One archive byte is taken every cycle unless in_stall_o is high; its result, if any, is
// registered in the output register, or in the skid register while the output is stalled.
// in_stall_o rises only while the skid register holds a beat behind a stalled output.
// Reset is asynchronous and leaves the block ready for a header at once.
`default_nettype none

`include "assert_macros.svh"

module tar_member_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  stream_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       data_byte_o,
  output logic             member_kind_o,
  output logic             member_last_o,
  output logic             archive_end_o,
  output logic [31:0]      member_number_o
);

  tmd_pkg::phase_e             phase_q, phase_d;
  tmd_pkg::kind_e              kind_q, kind_d;
  logic [31:0]                 remaining_q, remaining_d;
  logic [tmd_pkg::HdrCntW-1:0] pad_q, pad_d;
  logic [31:0]                 sel_q, sel_d;
  logic [31:0]                 rem_dec;
  logic [tmd_pkg::HdrCntW-1:0] pad_new;
  logic                        in_beat;
  logic                        hdr_beat;
  logic                        stage_full;
  logic                        res_valid;
  tmd_pkg::res_t               res;
  tmd_pkg::res_t               out_res;
  tmd_pkg::hdr_info_t          info;

  assign in_beat  = in_valid_i && !stage_full;
  assign hdr_beat = in_beat && (phase_q == tmd_pkg::PH_HDR);
  assign rem_dec  = remaining_q - 32'd1;
  assign pad_new  = (~info.size[tmd_pkg::HdrCntW-1:0]) + tmd_pkg::HdrCntW'(1);

  tmd_hdr_parse u_hdr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hdr_beat_i (hdr_beat),
    .byte_i     (stream_byte_i),
    .info_o     (info)
  );

  // Advance through header, data and padding
  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    remaining_d = remaining_q;
    pad_d       = pad_q;
    sel_d       = sel_q;
    res_valid   = 1'b0;
    res         = '0;
    case (phase_q)
      tmd_pkg::PH_HDR: begin
        if (info.done) begin
          if (info.arch_end) begin
            phase_d           = tmd_pkg::PH_END;
            res_valid         = 1'b1;
            res.archive_end   = 1'b1;
            res.member_number = sel_q;
          end else begin
            remaining_d = info.size;
            pad_d       = pad_new;
            kind_d      = info.kind;
            if (info.kind != tmd_pkg::KIND_NONE) begin
              sel_d = sel_q + 32'd1;
            end
            if (info.size != '0) begin
              phase_d = tmd_pkg::PH_DATA;
            end else begin
              phase_d = tmd_pkg::PH_HDR;
            end
          end
        end
      end
      tmd_pkg::PH_DATA: begin
        if (in_beat) begin
          remaining_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = (pad_q != '0) ? tmd_pkg::PH_PAD : tmd_pkg::PH_HDR;
          end
          if (kind_q != tmd_pkg::KIND_NONE) begin
            res_valid         = 1'b1;
            res.data_byte     = stream_byte_i;
            res.member_kind   = kind_q[0];
            res.member_last   = (rem_dec == '0);
            res.member_number = sel_q;
          end
        end
      end
      tmd_pkg::PH_PAD: begin
        if (in_beat) begin
          pad_d = pad_q - tmd_pkg::HdrCntW'(1);
          if (pad_q == tmd_pkg::HdrCntW'(1)) begin
            phase_d = tmd_pkg::PH_HDR;
          end
        end
      end
      tmd_pkg::PH_END: begin
        // drop everything after the end marker
        phase_d = tmd_pkg::PH_END;
      end
      default: begin
        phase_d = tmd_pkg::PH_HDR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tmd_pkg::PH_HDR;
      kind_q      <= tmd_pkg::KIND_NONE;
      remaining_q <= '0;
      pad_q       <= '0;
      sel_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      remaining_q <= remaining_d;
      pad_q       <= pad_d;
      sel_q       <= sel_d;
    end
  end

  tmd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (stage_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign in_stall_o      = stage_full;
  assign data_byte_o     = out_res.data_byte;
  assign member_kind_o   = out_res.member_kind;
  assign member_last_o   = out_res.member_last;
  assign archive_end_o   = out_res.archive_end;
  assign member_number_o = out_res.member_number;

  `TMD_ASSERT_NEXT(a_end_sticks, clk_i, rst_ni, phase_q == tmd_pkg::PH_END, phase_q == tmd_pkg::PH_END, "left the ended phase")
  `TMD_ASSERT(a_data_has_bytes, clk_i, rst_ni, phase_q != tmd_pkg::PH_DATA || remaining_q != '0, "data phase with no bytes left")
  `TMD_ASSERT(a_pad_has_bytes, clk_i, rst_ni, phase_q != tmd_pkg::PH_PAD || pad_q != '0, "pad phase with no bytes left")

endmodule

`default_nettype wire
